// ===== rtl/core/glcd_pkg.sv =====
// Shared types and constants for the dual-half graphic LCD controller.
package glcd_pkg;

    // Bus access kinds
    typedef enum logic [1:0] {
        OP_INSTR  = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    // Instruction bytes and the masks that pick out their opcode bits
    localparam logic [7:0] INSTR_PAGE   = 8'hB8;
    localparam logic [7:0] INSTR_COLUMN = 8'h40;
    localparam logic [7:0] INSTR_ON     = 8'h3F;
    localparam logic [7:0] INSTR_OFF    = 8'h3E;
    localparam logic [7:0] PAGE_MASK    = 8'hF8;
    localparam logic [7:0] COLUMN_MASK  = 8'hC0;

    // Status byte bit that reports display off
    localparam int STATUS_OFF_BIT = 5;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic exec;   // execute the accepted request, capture the result
        logic load;   // reload the read latches from RAM read data
    } cmd_t;

endpackage

// ===== rtl/core/glcd_ctrl.sv =====
// Sequencer: request handshake and datapath command generation.
module glcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    output logic                out_valid,
    input  logic                out_stall,
    output glcd_pkg::cmd_t      cmd
);

    glcd_pkg::state_t state_reg;
    glcd_pkg::state_t state_next;
    logic             in_accept;
    logic             out_accept;

    // Handshake
    assign in_stall   = (state_reg != glcd_pkg::S_IDLE);
    assign out_valid  = (state_reg == glcd_pkg::S_OUT);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    assign cmd.exec = in_accept;
    assign cmd.load = (state_reg == glcd_pkg::S_LOAD);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            glcd_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == glcd_pkg::OP_READ)
                        state_next = glcd_pkg::S_LOAD;
                    else
                        state_next = glcd_pkg::S_OUT;
                end
            end
            glcd_pkg::S_LOAD:
                state_next = glcd_pkg::S_OUT;
            glcd_pkg::S_OUT:
            begin
                if (out_accept)
                    state_next = glcd_pkg::S_IDLE;
            end
            default:
                state_next = glcd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= glcd_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // A data read always reloads the latch before its result is presented
    a_read_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == glcd_pkg::OP_READ) |=> (cmd.load && !out_valid))
        else $error("data read did not reload the latch");

    // Other requests present their result in the next cycle
    a_other_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op != glcd_pkg::OP_READ) |=> (out_valid && !cmd.load))
        else $error("result not presented after request");

    // No new request while a result is pending or the latch reloads
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid || cmd.load) |-> !cmd.exec)
        else $error("request accepted while busy");

    // A taken result frees the input side
    a_out_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept |=> (!out_valid && !in_stall))
        else $error("block stayed busy after result was taken");

endmodule

// ===== rtl/core/glcd_dp.sv =====
// Datapath: per-half address, display and latch registers, display RAMs, result register.
module glcd_dp #(
    parameter int COLUMNS_PER_HALF = 64,
    parameter int PAGES            = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  glcd_pkg::cmd_t      cmd,
    input  logic [1:0]          op,
    input  logic                sel_left,
    input  logic                sel_right,
    input  logic [7:0]          bus_data,
    output logic [7:0]          read_data,
    output logic                left_on,
    output logic                right_on
);

    localparam int DEPTH = PAGES * COLUMNS_PER_HALF;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS_PER_HALF);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS_PER_HALF);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS_PER_HALF - 1);
    localparam logic [6:0]    COLS_7    = 7'(COLUMNS_PER_HALF);
    localparam logic [3:0]    PAGES_4   = 4'(PAGES);

    // Per-half state
    logic [PW-1:0] page_reg   [2];
    logic [PW-1:0] page_next  [2];
    logic [CW-1:0] column_reg [2];
    logic [CW-1:0] column_next[2];
    logic          on_reg     [2];
    logic          on_next    [2];
    logic [7:0]    latch_reg  [2];
    logic [7:0]    rdata_reg  [2];
    logic [7:0]    half_out   [2];
    logic [AW-1:0] addr       [2];
    logic          sel        [2];
    logic          sel_reg    [2];

    // Result register
    logic [7:0] read_data_reg;
    logic [7:0] read_data_next;
    logic       left_on_reg;
    logic       right_on_reg;

    // Instruction operands reduced into range
    logic [6:0]    col_mod;
    logic [3:0]    page_mod;
    logic [CW-1:0] col_instr;
    logic [PW-1:0] page_instr;

    assign sel[0] = sel_left;
    assign sel[1] = sel_right;

    // Column operand modulo the half width (at most three subtractions)
    always_comb
    begin
        col_mod = {1'b0, bus_data[5:0]};
        for (int i = 0; i < 3; i++)
        begin
            if (col_mod >= COLS_7)
                col_mod = col_mod - COLS_7;
        end
    end

    // Page operand modulo the page count
    always_comb
    begin
        page_mod = {1'b0, bus_data[2:0]};
        for (int i = 0; i < 7; i++)
        begin
            if (page_mod >= PAGES_4)
                page_mod = page_mod - PAGES_4;
        end
    end

    assign col_instr  = col_mod[CW-1:0];
    assign page_instr = page_mod[PW-1:0];

    for (genvar h = 0; h < 2; h++)
    begin : g_half
        logic [7:0] mem [DEPTH];
        logic       act;

        assign act     = cmd.exec && sel[h];
        assign addr[h] = AW'(page_reg[h]) * COLS_A + AW'(column_reg[h]);

        // Byte this half drives on a read or status request
        always_comb
        begin
            half_out[h] = '0;
            if (op == glcd_pkg::OP_READ)
                half_out[h] = latch_reg[h];
            else if (op == glcd_pkg::OP_STATUS)
                half_out[h][glcd_pkg::STATUS_OFF_BIT] = !on_reg[h];
        end

        // Register updates for this half
        always_comb
        begin
            page_next[h]   = page_reg[h];
            column_next[h] = column_reg[h];
            on_next[h]     = on_reg[h];
            if (act)
            begin
                case (op)
                    glcd_pkg::OP_INSTR:
                    begin
                        if (bus_data == glcd_pkg::INSTR_ON)
                            on_next[h] = 1'b1;
                        else if (bus_data == glcd_pkg::INSTR_OFF)
                            on_next[h] = 1'b0;
                        else if ((bus_data & glcd_pkg::COLUMN_MASK) == glcd_pkg::INSTR_COLUMN)
                            column_next[h] = col_instr;
                        else if ((bus_data & glcd_pkg::PAGE_MASK) == glcd_pkg::INSTR_PAGE)
                            page_next[h] = page_instr;
                    end
                    glcd_pkg::OP_WRITE,
                    glcd_pkg::OP_READ:
                    begin
                        if (column_reg[h] == COL_LAST)
                            column_next[h] = '0;
                        else
                            column_next[h] = column_reg[h] + 1'b1;
                    end
                    default:
                    begin
                        on_next[h] = on_reg[h];
                    end
                endcase
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                page_reg[h]   <= '0;
                column_reg[h] <= '0;
                on_reg[h]     <= 1'b0;
                latch_reg[h]  <= '0;
                sel_reg[h]    <= 1'b0;
            end
            else
            begin
                page_reg[h]   <= page_next[h];
                column_reg[h] <= column_next[h];
                on_reg[h]     <= on_next[h];
                if (cmd.exec)
                    sel_reg[h] <= sel[h];
                if (cmd.load && sel_reg[h])
                    latch_reg[h] <= rdata_reg[h];
            end
        end

        // Display RAM: write on data write, registered read on data read
        always_ff @(posedge clk)
        begin
            if (act && op == glcd_pkg::OP_WRITE)
                mem[addr[h]] <= bus_data;
            if (act && op == glcd_pkg::OP_READ)
                rdata_reg[h] <= mem[addr[h]];
        end
    end

    // Result byte: left half wins when both are selected
    always_comb
    begin
        read_data_next = '0;
        if (sel_left)
            read_data_next = half_out[0];
        else if (sel_right)
            read_data_next = half_out[1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            read_data_reg <= read_data_next;
            left_on_reg   <= on_next[0];
            right_on_reg  <= on_next[1];
        end
    end

    assign read_data = read_data_reg;
    assign left_on   = left_on_reg;
    assign right_on  = right_on_reg;

endmodule

// ===== rtl/core/dual_half_graphic_lcd_controller.sv =====
// Top level of the dual-half page-organized graphic LCD controller.
// Each input request is one bus access (instruction write, data write, data read or status
// read) to the left and/or right half, and each produces exactly one result holding the read
// byte and both display-on flags. One request is handled at a time; data reads first pass
// through the latch reload state, other requests go straight to presenting their result, and
// a result is held under out_stall until taken. The reload state exists because each half's
// display RAM reads through a register, whose data reloads the read latch. The RAM holds no
// reset value, so a location never written reads as undefined data; a data read returns the
// latch from before the request, so the first read after an address change is a dummy read.
module dual_half_graphic_lcd_controller #(
    parameter int COLUMNS_PER_HALF = 64,
    parameter int PAGES            = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic       sel_left,
    input  logic       sel_right,
    input  logic [7:0] bus_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       left_on,
    output logic       right_on
);

    glcd_pkg::cmd_t cmd;

    // Sequencer
    glcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath
    glcd_dp #(
        .COLUMNS_PER_HALF (COLUMNS_PER_HALF),
        .PAGES            (PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op        (op),
        .sel_left  (sel_left),
        .sel_right (sel_right),
        .bus_data  (bus_data),
        .read_data (read_data),
        .left_on   (left_on),
        .right_on  (right_on)
    );

endmodule
